// File: hw/rtl/b64td_pkg.sv
package b64td_pkg;

  localparam logic [5:0] LOWER_BASE  = 6'd26;
  localparam logic [5:0] DIGIT_BASE  = 6'd52;
  localparam logic [5:0] PLUS_SEXTET = 6'd62;
  localparam logic [5:0] SLASH_SEXTET = 6'd63;
  localparam logic [7:0] PAD_CHAR    = 8'h3D;

  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  count;
  } emit_t;

  typedef struct packed {
    logic [1:0] count;
    logic [1:0] pads;
  } grp_t;

endpackage

// File: hw/rtl/b64td_core.sv
module b64td_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         text_char,
  input  logic               end_of_text,
  output b64td_pkg::emit_t   emit,
  output b64td_pkg::grp_t    grp
);

  logic [17:0] accum;
  logic [1:0]  count;
  logic [1:0]  pads;
  logic [17:0] accum_next;
  logic [1:0]  count_next;
  logic [1:0]  pads_next;

  always_comb begin
    logic       sym;
    logic       pad;
    logic [5:0] v;
    logic [1:0] p;
    logic [7:0] off;
    sym = 1'b1;
    pad = 1'b0;
    v   = 6'd0;
    off = 8'd0;
    if (text_char >= 8'h41 && text_char <= 8'h5A) begin
      off = text_char - 8'h41;
      v   = off[5:0];
    end else if (text_char >= 8'h61 && text_char <= 8'h7A) begin
      off = text_char - 8'h61;
      v   = off[5:0] + b64td_pkg::LOWER_BASE;
    end else if (text_char >= 8'h30 && text_char <= 8'h39) begin
      off = text_char - 8'h30;
      v   = off[5:0] + b64td_pkg::DIGIT_BASE;
    end else if (text_char == 8'h2B) begin
      v = b64td_pkg::PLUS_SEXTET;
    end else if (text_char == 8'h2F) begin
      v = b64td_pkg::SLASH_SEXTET;
    end else if (text_char == b64td_pkg::PAD_CHAR) begin
      pad = 1'b1;
    end else begin
      sym = 1'b0;
    end

    p = (pads == 2'd3) ? 2'd3 : pads + {1'b0, pad};

    accum_next = accum;
    count_next = count;
    pads_next  = pads;
    emit.word  = 24'd0;
    emit.count = 2'd0;

    if (sym) begin
      if (count == 2'd3) begin
        emit.word  = {accum, v};
        emit.count = ~p;
        accum_next = 18'd0;
        count_next = 2'd0;
        pads_next  = 2'd0;
      end else begin
        accum_next = {accum[11:0], v};
        count_next = count + 2'd1;
        pads_next  = p;
      end
    end

    if (end_of_text) begin
      unique case (count_next)
        2'd3:    emit.word = {accum_next, 6'd0};
        2'd2:    emit.word = {accum_next[11:0], 12'd0};
        2'd1:    emit.word = {accum_next[5:0], 18'd0};
        default: emit.word = emit.word;
      endcase
      if (count_next != 2'd0) begin
        emit.count = ~pads_next;
      end
      accum_next = 18'd0;
      count_next = 2'd0;
      pads_next  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= 18'd0;
      count <= 2'd0;
      pads  <= 2'd0;
    end else if (take) begin
      accum <= accum_next;
      count <= count_next;
      pads  <= pads_next;
    end
  end

  assign grp.count = count;
  assign grp.pads  = pads;

endmodule

// File: hw/rtl/b64td_serialiser.sv
module b64td_serialiser (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  b64td_pkg::emit_t emit,
  output logic             free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // data_byte
  output logic             m_tlast    // run_last
);

  logic [1:0]  remaining;
  logic [23:0] word;

  assign m_tvalid = remaining != 2'd0;
  assign m_tdata  = word[23:16];
  assign m_tlast  = remaining == 2'd1;
  assign free     = (remaining == 2'd0) || (remaining == 2'd1 && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
    end else if (load) begin
      remaining <= emit.count;
    end else if (m_tvalid && m_tready) begin
      remaining <= remaining - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= emit.word;
    end else if (m_tvalid && m_tready) begin
      word <= {word[15:0], 8'd0};
    end
  end

endmodule

// File: hw/rtl/base64_text_decoder_unit.sv
// A character is held in the input register, its bytes then in the byte buffer.
// Throughput: one character per cycle, but for the waits below. Bytes leave one per cycle
// while m_tready is high, from a three-byte shift buffer; only a character that releases
// bytes waits, until that buffer holds at most its last byte. A full four-character group
// waits only under back-pressure; a short message end can wait behind earlier bytes.
// Reset (rst, synchronous): clears the group state, input register and byte buffer.
module base64_text_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // text_char
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // data_byte
  output logic       m_tlast    // run_last
);

  logic             in_valid;
  logic [7:0]       in_char;
  logic             in_eot;
  logic             buf_free;
  logic             take;
  logic             load;
  b64td_pkg::emit_t emit;
  b64td_pkg::grp_t  grp;

  assign take     = in_valid && (buf_free || emit.count == 2'd0);
  assign load     = take && (emit.count != 2'd0);
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_eot  <= s_tlast;
    end
  end

  b64td_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .text_char   (in_char),
    .end_of_text (in_eot),
    .emit        (emit),
    .grp         (grp)
  );

  b64td_serialiser u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .emit     (emit),
    .free     (buf_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && in_eot |=> grp.count == 2'd0 && grp.pads == 2'd0)
    else $error("group state not cleared after end of text");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && !buf_free)
    else $error("input stalled without a pending character");

  a_no_byte_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast && !load |=> !m_tvalid)
    else $error("byte appeared after last of a run without a new load");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    load |-> !m_tvalid || (m_tlast && m_tready))
    else $error("buffer loaded while bytes still pending");

endmodule
